// ----- hw/rtl/jst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jst_pkg
// Token codes, character constants, keyword tables and helper functions
// for the JSON stream tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 4;

    localparam logic [KIND_W-1:0] TK_OBJ_OPEN  = 4'd0;
    localparam logic [KIND_W-1:0] TK_OBJ_CLOSE = 4'd1;
    localparam logic [KIND_W-1:0] TK_ARR_OPEN  = 4'd2;
    localparam logic [KIND_W-1:0] TK_ARR_CLOSE = 4'd3;
    localparam logic [KIND_W-1:0] TK_COLON     = 4'd4;
    localparam logic [KIND_W-1:0] TK_COMMA     = 4'd5;
    localparam logic [KIND_W-1:0] TK_STR_END   = 4'd6;
    localparam logic [KIND_W-1:0] TK_TRUE      = 4'd7;
    localparam logic [KIND_W-1:0] TK_FALSE     = 4'd8;
    localparam logic [KIND_W-1:0] TK_NULL      = 4'd9;
    localparam logic [KIND_W-1:0] TK_NUMBER    = 4'd10;
    localparam logic [KIND_W-1:0] TK_CONTENT   = 4'd11;
    localparam logic [KIND_W-1:0] TK_ERROR     = 4'd12;

    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_FF        = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

    localparam logic [BYTE_W-1:0] KW_TEXT [0:2][0:7] = '{
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [0:2] = '{3'd4, 3'd5, 3'd4};
    localparam logic [KIND_W-1:0] KW_TOKEN [0:2] = '{TK_TRUE, TK_FALSE, TK_NULL};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } token_t;

    function automatic logic [2:0] kw_flags_update(input logic [2:0] flags,
                                                   input logic [2:0] pos,
                                                   input logic [BYTE_W-1:0] b);
        logic [2:0] f;
        f = flags;
        for (int k = 0; k < 3; k++) begin
            if (pos < KW_LEN[k] && b != KW_TEXT[k][pos])
            begin
                f[k] = 1'b0;
            end
        end
        return f;
    endfunction

    function automatic logic [KIND_W-1:0] literal_kind(input logic [2:0] flags,
                                                       input logic [2:0] pos);
        logic [KIND_W-1:0] kind;
        kind = TK_NUMBER;
        for (int k = 2; k >= 0; k--) begin
            if (flags[k] && pos >= KW_LEN[k])
            begin
                kind = KW_TOKEN[k];
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jst_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jst_byte_if / jst_token_if
// Valid/ready channels for raw input bytes and for result tokens.
// ----------------------------------------------------------------------------
interface jst_byte_if import jst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jst_token_if import jst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [BYTE_W-1:0] content_byte;
    logic              last_of_input;

    modport source (output valid, output token_kind, output content_byte,
                    output last_of_input, input ready);
    modport sink   (input valid, input token_kind, input content_byte,
                    input last_of_input, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/json_stream_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// json_stream_tokenizer
// Byte-wide JSON tokenizer: punctuation, string content, literal keywords
// and a sticky error, results through a four-entry output queue.
// ----------------------------------------------------------------------------
// The results of a byte are registered in the output queue before they are offered.
// Throughput: one byte per cycle while the queue has room; the single output port
// drains one queue entry per cycle.
// Input is held off while fewer than two queue entries are free.
// Reset clears scan state, sticky error and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module json_stream_tokenizer import jst_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    jst_byte_if.sink   bytes,
    jst_token_if.source tokens
);

    localparam logic [1:0] MODE_SEARCH  = 2'd0;
    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_LITERAL = 2'd2;

    logic [1:0] mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       err_reg, err_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] flags_reg, flags_next;

    token_t     fifo_reg [0:3];
    logic [1:0] rd_ptr_reg, wr_ptr_reg;
    logic [2:0] count_reg, count_next;

    logic [1:0]        n;
    token_t            r0, r1;
    logic [BYTE_W-1:0] b;
    logic              push, pop;

    assign b = bytes.in_byte;

    always_comb
    begin
        n          = 2'd0;
        r0         = '0;
        r1         = '0;
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        err_next   = err_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        if (!err_reg)
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    n = 2'd1;
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        r0.kind  = TK_CONTENT;
                        r0.data  = b;
                    end
                    else if (b == CH_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                        r0.kind  = TK_CONTENT;
                        r0.data  = b;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_SEARCH;
                        r0.kind   = TK_STR_END;
                    end
                    else
                    begin
                        r0.kind = TK_CONTENT;
                        r0.data = b;
                    end
                end
                MODE_LITERAL:
                begin
                    if (b == CH_COMMA || b == CH_RBRACKET || b == CH_RBRACE)
                    begin
                        n          = 2'd2;
                        r0.kind    = literal_kind(flags_reg, pos_reg);
                        mode_next  = MODE_SEARCH;
                        pos_next   = 3'd0;
                        flags_next = 3'b111;
                        if (b == CH_COMMA)
                        begin
                            r1.kind = TK_COMMA;
                        end
                        else if (b == CH_RBRACKET)
                        begin
                            r1.kind = TK_ARR_CLOSE;
                        end
                        else
                        begin
                            r1.kind = TK_OBJ_CLOSE;
                        end
                    end
                    else
                    begin
                        n          = 2'd1;
                        r0.kind    = TK_CONTENT;
                        r0.data    = b;
                        flags_next = kw_flags_update(flags_reg, pos_reg, b);
                        pos_next   = (pos_reg != 3'd7) ? pos_reg + 3'd1 : pos_reg;
                    end
                end
                default:
                begin
                    mode_next = MODE_SEARCH;
                    case (b) inside
                        CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF:
                        begin
                            n = 2'd0;
                        end
                        CH_LBRACE:
                        begin
                            n       = 2'd1;
                            r0.kind = TK_OBJ_OPEN;
                        end
                        CH_RBRACE:
                        begin
                            n       = 2'd1;
                            r0.kind = TK_OBJ_CLOSE;
                        end
                        CH_LBRACKET:
                        begin
                            n       = 2'd1;
                            r0.kind = TK_ARR_OPEN;
                        end
                        CH_RBRACKET:
                        begin
                            n       = 2'd1;
                            r0.kind = TK_ARR_CLOSE;
                        end
                        CH_COLON:
                        begin
                            n       = 2'd1;
                            r0.kind = TK_COLON;
                        end
                        CH_COMMA:
                        begin
                            n       = 2'd1;
                            r0.kind = TK_COMMA;
                        end
                        CH_QUOTE:
                        begin
                            mode_next = MODE_STRING;
                            esc_next  = 1'b0;
                        end
                        CH_BACKSLASH:
                        begin
                            n        = 2'd1;
                            r0.kind  = TK_ERROR;
                            err_next = 1'b1;
                        end
                        default:
                        begin
                            n          = 2'd1;
                            r0.kind    = TK_CONTENT;
                            r0.data    = b;
                            mode_next  = MODE_LITERAL;
                            pos_next   = 3'd1;
                            flags_next = kw_flags_update(3'b111, 3'd0, b);
                        end
                    endcase
                end
            endcase
        end
        r0.last = (n == 2'd1);
        r1.last = (n == 2'd2);
    end

    assign bytes.ready = (count_reg <= 3'd2);
    assign push        = bytes.valid && bytes.ready;
    assign pop         = tokens.valid && tokens.ready;
    assign count_next  = count_reg + (push ? {1'b0, n} : 3'd0) - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SEARCH;
            esc_reg    <= 1'b0;
            err_reg    <= 1'b0;
            pos_reg    <= 3'd0;
            flags_reg  <= 3'b111;
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                mode_reg   <= mode_next;
                esc_reg    <= esc_next;
                err_reg    <= err_next;
                pos_reg    <= pos_next;
                flags_reg  <= flags_next;
                wr_ptr_reg <= wr_ptr_reg + n;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= r0;
        end
        if (push && n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= r1;
        end
    end

    assign tokens.valid         = (count_reg != 3'd0);
    assign tokens.token_kind    = fifo_reg[rd_ptr_reg].kind;
    assign tokens.content_byte  = fifo_reg[rd_ptr_reg].data;
    assign tokens.last_of_input = fifo_reg[rd_ptr_reg].last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("output queue overfilled");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[1:0] == wr_ptr_reg - rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (n == 2'd0))
        else $error("result produced after sticky error");

    a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("sticky error cleared");

    a_lit_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (push && n == 2'd2) |=> (mode_reg == MODE_SEARCH && pos_reg == 3'd0))
        else $error("literal not closed after terminator");

endmodule

`default_nettype wire

// ----- bench/json_stream_tokenizer_tb.sv -----
// ----------------------------------------------------------------------------
// json_stream_tokenizer_tb
// Self-checking bench for the byte-wide JSON tokenizer. A directed opening
// covers punctuation, whitespace, escaped quotes, the three keywords and odd
// literals. Random JSON fragments with random content follow, with noise in
// between, and a stray backslash at the end raises the sticky error. A predictor
// forms the expected tokens of each accepted byte, and a monitor compares every
// token transaction field by field. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_tb import jst_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 900;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum logic [1:0] {SCAN_SEARCH, SCAN_STRING, SCAN_LITERAL} scan_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              drain;
    } text_item_t;

    localparam logic [BYTE_W-1:0] WORD_CHARS [0:2][0:4] = '{
        '{"t", "r", "u", "e", 8'h00},
        '{"f", "a", "l", "s", "e"},
        '{"n", "u", "l", "l", 8'h00}
    };
    localparam int WORD_LEN [0:2] = '{4, 5, 4};
    localparam logic [KIND_W-1:0] WORD_KIND [0:2] = '{TK_TRUE, TK_FALSE, TK_NULL};
    localparam logic [BYTE_W-1:0] LONE_CHARS [0:10] = '{
        CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON, CH_COMMA,
        CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF
    };
    localparam string NUM_CHARS = "-0123456789.eE+";

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              drv_valid = 1'b0;
    logic [BYTE_W-1:0] drv_byte = '0;
    logic              sink_ready = 1'b0;

    scan_mode_t        scan_mode = SCAN_SEARCH;
    logic              escape_pending = 1'b0;
    logic              error_seen = 1'b0;
    logic [2:0]        lit_count = 3'd0;
    logic [2:0]        lit_match = 3'b111;

    text_item_t        text_q[$];
    token_t            token_q[$];
    text_item_t        next_item;
    token_t            want;
    int                errors = 0;
    int                cycle_count = 0;
    int                byte_gap = 0;
    int                byte_burst = 0;
    int                token_gap = 0;
    int                token_burst = 0;

    jst_byte_if  bytes_if ();
    jst_token_if tokens_if ();

    assign bytes_if.valid   = drv_valid;
    assign bytes_if.in_byte = drv_byte;
    assign tokens_if.ready  = sink_ready;

    json_stream_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes_if),
        .tokens (tokens_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit punct_kind(input logic [BYTE_W-1:0] b,
                                      output logic [KIND_W-1:0] kind);
        kind = TK_COMMA;
        case (b)
            CH_LBRACE:   kind = TK_OBJ_OPEN;
            CH_RBRACE:   kind = TK_OBJ_CLOSE;
            CH_LBRACKET: kind = TK_ARR_OPEN;
            CH_RBRACKET: kind = TK_ARR_CLOSE;
            CH_COLON:    kind = TK_COLON;
            CH_COMMA:    kind = TK_COMMA;
            default:     return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                          input logic [BYTE_W-1:0] data);
        token_t t;
        t.kind = kind;
        t.data = data;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void absorb_literal(input logic [BYTE_W-1:0] b);
        for (int k = 0; k < 3; k++)
        begin
            if (lit_count < WORD_LEN[k] && b != WORD_CHARS[k][lit_count])
            begin
                lit_match[k] = 1'b0;
            end
        end
        if (lit_count != 3'd7)
        begin
            lit_count = lit_count + 3'd1;
        end
    endfunction

    function automatic void tokenize(input logic [BYTE_W-1:0] b);
        token_t            found[$];
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] word;
        bit                matched;
        if (error_seen)
        begin
            return;
        end
        case (scan_mode)
            SCAN_STRING:
            begin
                if (escape_pending)
                begin
                    escape_pending = 1'b0;
                    found.push_back(make_token(TK_CONTENT, b));
                end
                else if (b == CH_BACKSLASH)
                begin
                    escape_pending = 1'b1;
                    found.push_back(make_token(TK_CONTENT, b));
                end
                else if (b == CH_QUOTE)
                begin
                    scan_mode = SCAN_SEARCH;
                    found.push_back(make_token(TK_STR_END, '0));
                end
                else
                begin
                    found.push_back(make_token(TK_CONTENT, b));
                end
            end
            SCAN_LITERAL:
            begin
                if (b == CH_COMMA || b == CH_RBRACKET || b == CH_RBRACE)
                begin
                    word = TK_NUMBER;
                    matched = 1'b0;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (!matched && lit_match[k] && lit_count >= WORD_LEN[k])
                        begin
                            word = WORD_KIND[k];
                            matched = 1'b1;
                        end
                    end
                    found.push_back(make_token(word, '0));
                    void'(punct_kind(b, kind));
                    found.push_back(make_token(kind, '0));
                    scan_mode = SCAN_SEARCH;
                    lit_count = 3'd0;
                    lit_match = 3'b111;
                end
                else
                begin
                    absorb_literal(b);
                    found.push_back(make_token(TK_CONTENT, b));
                end
            end
            default:
            begin
                if (punct_kind(b, kind))
                begin
                    found.push_back(make_token(kind, '0));
                end
                else if (b == CH_QUOTE)
                begin
                    scan_mode = SCAN_STRING;
                    escape_pending = 1'b0;
                end
                else if (b == CH_BACKSLASH)
                begin
                    error_seen = 1'b1;
                    found.push_back(make_token(TK_ERROR, '0));
                end
                else if (!(b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF}))
                begin
                    scan_mode = SCAN_LITERAL;
                    lit_count = 3'd0;
                    lit_match = 3'b111;
                    absorb_literal(b);
                    found.push_back(make_token(TK_CONTENT, b));
                end
            end
        endcase
        if (found.size() > 0)
        begin
            found[found.size()-1].last = 1'b1;
        end
        foreach (found[i])
        begin
            token_q.push_back(found[i]);
        end
    endfunction

    function automatic int draw_pause(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // lead: first byte of a literal, so no whitespace, punctuation, quote or backslash
    function automatic logic [BYTE_W-1:0] pick_byte(input bit lead);
        logic [BYTE_W-1:0] b;
        bit                bad;
        do
        begin
            b = $urandom_range(0, 255);
            bad = b inside {CH_COMMA, CH_RBRACKET, CH_RBRACE};
            if (lead)
            begin
                bad = bad || (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_FF, CH_LBRACE,
                                        CH_LBRACKET, CH_COLON, CH_QUOTE, CH_BACKSLASH});
            end
        end
        while (bad);
        return b;
    endfunction

    task automatic put_byte(input logic [BYTE_W-1:0] v);
        text_item_t t;
        t.value = v;
        t.drain = 1'b0;
        text_q.push_back(t);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_byte(s[i]);
        end
    endtask

    task automatic gen_string();
        int                n;
        logic [BYTE_W-1:0] b;
        n = $urandom_range(0, 8);
        put_byte(CH_QUOTE);
        repeat (n)
        begin
            b = $urandom_range(0, 255);
            if (b == CH_QUOTE)
            begin
                put_byte(CH_BACKSLASH);
                put_byte(CH_QUOTE);
            end
            else if (b == CH_BACKSLASH)
            begin
                put_byte(CH_BACKSLASH);
                put_byte($urandom_range(0, 255));
            end
            else
            begin
                put_byte(b);
            end
        end
        put_byte(CH_QUOTE);
    endtask

    task automatic gen_literal();
        int k;
        int n;
        case ($urandom_range(0, 3))
            0, 1:
            begin
                k = $urandom_range(0, 2);
                n = $urandom_range(1, WORD_LEN[k] + 2);
                for (int i = 0; i < n; i++)
                begin
                    if (i < WORD_LEN[k] && $urandom_range(0, 7) != 0)
                    begin
                        put_byte(WORD_CHARS[k][i]);
                    end
                    else
                    begin
                        put_byte(pick_byte(i == 0));
                    end
                end
            end
            2:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    put_byte(NUM_CHARS[$urandom_range(0, NUM_CHARS.len() - 1)]);
                end
            end
            default:
            begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                begin
                    put_byte(pick_byte(i == 0));
                end
            end
        endcase
        case ($urandom_range(0, 2))
            0:       put_byte(CH_COMMA);
            1:       put_byte(CH_RBRACKET);
            default: put_byte(CH_RBRACE);
        endcase
    endtask

    // close with a comma so that a literal opened by the noise ends here
    task automatic gen_noise();
        int                n;
        logic [BYTE_W-1:0] b;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            do
            begin
                b = $urandom_range(0, 255);
            end
            while (b == CH_QUOTE || b == CH_BACKSLASH);
            put_byte(b);
        end
        put_byte(CH_COMMA);
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_byte  <= '0;
            byte_gap = 0;
        end
        else
        begin
            if (drv_valid && bytes_if.ready)
            begin
                tokenize(drv_byte);
            end
            if (!drv_valid || bytes_if.ready)
            begin
                if (byte_gap > 0)
                begin
                    byte_gap--;
                    drv_valid <= 1'b0;
                end
                else if (text_q.size() > 0 && !(text_q[0].drain && token_q.size() != 0))
                begin
                    next_item = text_q.pop_front();
                    drv_valid <= 1'b1;
                    drv_byte  <= next_item.value;
                    byte_gap = draw_pause(byte_burst);
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            token_gap = 0;
        end
        else
        begin
            if (tokens_if.valid && sink_ready)
            begin
                if (token_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected token kind %0d byte %02h",
                                              tokens_if.token_kind, tokens_if.content_byte));
                end
                else
                begin
                    want = token_q.pop_front();
                    if (tokens_if.token_kind !== want.kind)
                    begin
                        report_mismatch($sformatf("token_kind %0d, expected %0d",
                                                  tokens_if.token_kind, want.kind));
                    end
                    if (tokens_if.content_byte !== want.data)
                    begin
                        report_mismatch($sformatf("content_byte %02h, expected %02h",
                                                  tokens_if.content_byte, want.data));
                    end
                    if (tokens_if.last_of_input !== want.last)
                    begin
                        report_mismatch($sformatf("last_of_input %b, expected %b",
                                                  tokens_if.last_of_input, want.last));
                    end
                end
                token_gap = draw_pause(token_burst);
            end
            if (token_gap > 0)
            begin
                token_gap--;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int first_random;
        int settle;
        put_text("{\t\"\\\"\":trueX,");
        put_text("false]null}[");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(CH_FF);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("\" \\:}");
        first_random = text_q.size();
        while (text_q.size() - first_random < RANDOM_BYTES)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        put_byte(LONE_CHARS[$urandom_range(0, 10)]);
                    end
                end
                3, 4:    gen_string();
                5, 6, 7: gen_literal();
                default: gen_noise();
            endcase
        end
        text_q[first_random].drain = 1'b1;
        text_q[first_random + 300].drain = 1'b1;
        text_q[first_random + 600].drain = 1'b1;
        // backslash outside a string, then bytes that must be ignored
        put_byte(CH_BACKSLASH);
        put_byte(CH_LBRACE);
        put_byte($urandom_range(0, 255));
        put_byte(CH_QUOTE);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_q.size() != 0 || drv_valid)
        begin
            @(posedge clk);
        end
        settle = 0;
        while (token_q.size() != 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (10) @(posedge clk);
        if (token_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected tokens never arrived", token_q.size()));
        end
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
